// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define LDS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Consequence required in the cycle after the condition.
`define LDS_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/ldsau_pkg.sv =====
// Types and constants of the local data share access unit.
package ldsau_pkg;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 64;
    localparam int BOUND_W    = 17;
    localparam int LIMIT_W    = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int LANES      = 8;

    localparam logic [3:0] CMD_WR8    = 4'd0;
    localparam logic [3:0] CMD_WR16   = 4'd1;
    localparam logic [3:0] CMD_WR32   = 4'd2;
    localparam logic [3:0] CMD_WR64   = 4'd3;
    localparam logic [3:0] CMD_WR2X32 = 4'd4;
    localparam logic [3:0] CMD_WR2X64 = 4'd5;
    localparam logic [3:0] CMD_RDI8   = 4'd6;
    localparam logic [3:0] CMD_RDU8   = 4'd7;
    localparam logic [3:0] CMD_RDI16  = 4'd8;
    localparam logic [3:0] CMD_RDU16  = 4'd9;
    localparam logic [3:0] CMD_RD32   = 4'd10;
    localparam logic [3:0] CMD_RD64   = 4'd11;
    localparam logic [3:0] CMD_RD2X32 = 4'd12;
    localparam logic [3:0] CMD_RD2X64 = 4'd13;

    localparam logic REG_MEMORY_TOP = 1'b0;
    localparam logic REG_LIMIT      = 1'b1;

    localparam logic [BOUND_W-1:0] MEMORY_TOP_RESET = 17'h1_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [ADDR_W-1:0] base_address;
        logic [7:0]        offset_low;
        logic [7:0]        offset_high;
        logic [DATA_W-1:0] write_data_first;
        logic [DATA_W-1:0] write_data_second;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data_first;
        logic [DATA_W-1:0] read_data_second;
        logic [1:0]        access_count;
        logic [ADDR_W-1:0] access_address_first;
        logic [ADDR_W-1:0] access_address_second;
        logic [3:0]        access_bytes;
        logic              access_is_write;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic mem_en;
        logic use_second;
        logic cap_first;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pair;
    } dp_status_t;

endpackage

// ===== rtl/ldsau_ram.sv =====
// Generic single-port RAM with registered read.
module ldsau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ldsau_cfg.sv =====
// APB configuration registers and access bound of the local data share unit.
module ldsau_cfg import ldsau_pkg::*; #(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [BOUND_W-1:0]    bound
);

    localparam logic [BOUND_W-1:0] MEM_BOUND = BOUND_W'(MEMORY_BYTES);

    logic [BOUND_W-1:0] top_reg, top_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic               wr_en;

    assign wr_en = psel & penable & pwrite;

    always_comb begin
        top_next   = top_reg;
        limit_next = limit_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_MEMORY_TOP: top_next   = pwdata[BOUND_W-1:0];
                REG_LIMIT:      limit_next = pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        bound_next = top_next;
        if (limit_next < {{(LIMIT_W-BOUND_W){1'b0}}, bound_next}) begin
            bound_next = limit_next[BOUND_W-1:0];
        end
        if (MEM_BOUND < bound_next) begin
            bound_next = MEM_BOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= MEMORY_TOP_RESET;
            limit_reg <= LIMIT_RESET;
            bound_reg <= MEM_BOUND;
        end else begin
            top_reg   <= top_next;
            limit_reg <= limit_next;
            bound_reg <= bound_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MEMORY_TOP: prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, top_reg};
            REG_LIMIT:      prdata = limit_reg;
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign bound  = bound_reg;

endmodule

// ===== rtl/ldsau_ctrl.sv =====
// Sequencing state machine of the local data share unit.
module ldsau_ctrl import ldsau_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC0 = 2'd1;
    localparam logic [1:0] ST_ACC1 = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACC0;
                end
            end
            ST_ACC0: begin
                cmd.mem_en = 1'b1;
                state_next = status.is_pair ? ST_ACC1 : ST_FIN;
            end
            ST_ACC1: begin
                cmd.mem_en     = 1'b1;
                cmd.use_second = 1'b1;
                cmd.cap_first  = 1'b1;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/ldsau_dp.sv =====
// Address, byte-lane memory and result datapath of the local data share unit.
module ldsau_dp import ldsau_pkg::*; #(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic               aclk,
    input  in_item_t           s_data,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [BOUND_W-1:0] bound,
    output out_item_t          m_data
);

    localparam int ROWS  = (MEMORY_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [BOUND_W-1:0] MEM_BOUND = BOUND_W'(MEMORY_BYTES);

    logic [3:0]        cmd_reg;
    logic [ADDR_W-1:0] a0_reg, a1_reg;
    logic [DATA_W-1:0] d0_reg, d1_reg;
    logic [DATA_W-1:0] rd_first_reg;
    out_item_t         out_reg;

    logic [ADDR_W-1:0] a0_in, a1_in;
    logic              op_ok, is_wr, is_pair, sx8, sx16;
    logic [3:0]        size;
    logic              hit0, hit1;
    logic [ADDR_W-1:0] acc_addr;
    logic [DATA_W-1:0] acc_data;
    logic              acc_hit;
    logic [DATA_W-1:0] rd_row;
    logic [7:0]        lane_rdata [LANES];
    logic [DATA_W-1:0] ext0, ext1;
    out_item_t         out_next;

    function automatic logic [DATA_W-1:0] extract(
        input logic [DATA_W-1:0] row,
        input logic [ADDR_W-1:0] a,
        input logic [3:0]        n,
        input logic              s8,
        input logic              s16,
        input logic              hit
    );
        logic [DATA_W-1:0]  v;
        logic [2:0]         lane;
        logic [BOUND_W-1:0] ba;
        v = '0;
        for (int k = 0; k < LANES; k++) begin
            lane = a[2:0] + 3'(k);
            ba   = {1'b0, a[15:0]} + BOUND_W'(k);
            if (4'(k) < n && ba < MEM_BOUND) begin
                v[8*k +: 8] = 8'(row >> {lane, 3'b000});
            end
        end
        if (s8 && v[7]) begin
            v[DATA_W-1:8] = '1;
        end
        if (s16 && v[15]) begin
            v[DATA_W-1:16] = '1;
        end
        if (!hit) begin
            v = '0;
        end
        return v;
    endfunction

    always_comb begin
        case (s_data.cmd)
            CMD_WR2X32, CMD_RD2X32: begin
                a0_in = s_data.base_address + {22'd0, s_data.offset_low, 2'b00};
                a1_in = s_data.base_address + {22'd0, s_data.offset_high, 2'b00};
            end
            CMD_WR2X64, CMD_RD2X64: begin
                a0_in = s_data.base_address + {21'd0, s_data.offset_low, 3'b000};
                a1_in = s_data.base_address + {21'd0, s_data.offset_high, 3'b000};
            end
            default: begin
                a0_in = s_data.base_address + {16'd0, s_data.offset_high, s_data.offset_low};
                a1_in = s_data.base_address;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= s_data.cmd;
            a0_reg  <= a0_in;
            a1_reg  <= a1_in;
            d0_reg  <= s_data.write_data_first;
            d1_reg  <= s_data.write_data_second;
        end
    end

    always_comb begin
        op_ok   = 1'b1;
        is_wr   = 1'b0;
        is_pair = 1'b0;
        sx8     = 1'b0;
        sx16    = 1'b0;
        size    = 4'd0;
        case (cmd_reg)
            CMD_WR8:    begin is_wr = 1'b1; size = 4'd1; end
            CMD_WR16:   begin is_wr = 1'b1; size = 4'd2; end
            CMD_WR32:   begin is_wr = 1'b1; size = 4'd4; end
            CMD_WR64:   begin is_wr = 1'b1; size = 4'd8; end
            CMD_WR2X32: begin is_wr = 1'b1; is_pair = 1'b1; size = 4'd4; end
            CMD_WR2X64: begin is_wr = 1'b1; is_pair = 1'b1; size = 4'd8; end
            CMD_RDI8:   begin sx8 = 1'b1; size = 4'd1; end
            CMD_RDU8:   size = 4'd1;
            CMD_RDI16:  begin sx16 = 1'b1; size = 4'd2; end
            CMD_RDU16:  size = 4'd2;
            CMD_RD32:   size = 4'd4;
            CMD_RD64:   size = 4'd8;
            CMD_RD2X32: begin is_pair = 1'b1; size = 4'd4; end
            CMD_RD2X64: begin is_pair = 1'b1; size = 4'd8; end
            default:    op_ok = 1'b0;
        endcase
    end

    assign hit0 = op_ok && (a0_reg < {{(ADDR_W-BOUND_W){1'b0}}, bound});
    assign hit1 = op_ok && is_pair && (a1_reg < {{(ADDR_W-BOUND_W){1'b0}}, bound});

    assign acc_addr = cmd.use_second ? a1_reg : a0_reg;
    assign acc_data = cmd.use_second ? d1_reg : d0_reg;
    assign acc_hit  = cmd.use_second ? hit1 : hit0;

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        logic [2:0]         k;
        logic [BOUND_W-1:0] byte_addr;
        logic               lane_we;
        logic [ROW_W-1:0]   lane_addr;
        logic [7:0]         lane_wdata;

        assign k          = 3'(j) - acc_addr[2:0];
        assign byte_addr  = {1'b0, acc_addr[15:0]} + BOUND_W'(k);
        assign lane_we    = is_wr && acc_hit && (4'(k) < size) && (byte_addr < MEM_BOUND);
        assign lane_addr  = ROW_W'(byte_addr >> 3);
        assign lane_wdata = 8'(acc_data >> {k, 3'b000});

        ldsau_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .aclk  (aclk),
            .en    (cmd.mem_en),
            .we    (cmd.mem_en & lane_we),
            .addr  (lane_addr),
            .wdata (lane_wdata),
            .rdata (lane_rdata[j])
        );
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            rd_row[8*i +: 8] = lane_rdata[i];
        end
    end

    assign ext0 = extract(rd_row, a0_reg, size, sx8, sx16, hit0 & ~is_wr);
    assign ext1 = extract(rd_row, a1_reg, size, 1'b0, 1'b0, hit1 & ~is_wr);

    always_ff @(posedge aclk) begin
        if (cmd.cap_first) begin
            rd_first_reg <= ext0;
        end
    end

    always_comb begin
        out_next.read_data_first  = is_pair ? rd_first_reg : ext0;
        out_next.read_data_second = is_pair ? ext1 : '0;
        out_next.access_count     = {1'b0, hit0} + {1'b0, hit1};
        out_next.access_address_first  = hit0 ? a0_reg : (hit1 ? a1_reg : '0);
        out_next.access_address_second = (hit0 && hit1) ? a1_reg : '0;
        out_next.access_bytes     = (hit0 || hit1) ? size : 4'd0;
        out_next.access_is_write  = (hit0 || hit1) && is_wr;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign status.is_pair = is_pair;
    assign m_data         = out_reg;

endmodule

// ===== rtl/local_data_share_access_unit.sv =====
// Local data share access unit: one scratch-memory instruction per request.
// Steps: capture on acceptance, then ACC0, ACC1 for pair forms, and FIN, which
// loads the result once the output is free. A new request is taken only in IDLE;
// the single memory port serves one access per cycle, so a pair's two go in turn.
// Reset: synchronous, active low; clears control state and the configuration registers.
// Scratch contents are undefined after reset until written; no clearing pass.
module local_data_share_access_unit import ldsau_pkg::*; #(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [BOUND_W-1:0] bound;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    ldsau_cfg #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bound   (bound)
    );

    ldsau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ldsau_dp #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .bound  (bound),
        .m_data (m_data)
    );

endmodule

// ===== rtl/ldsau_checker.sv =====
// Port-level checker of the local data share unit and its bind.
`include "assert_macros.svh"

module ldsau_checker import ldsau_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `LDS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed while stalled")
    `LDS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready,
        "request taken while another is in flight")
    `LDS_ASSERT(a_count_range, aclk, aresetn,
        m_valid |-> (m_data.access_count != 2'd3), "access count out of range")
    `LDS_ASSERT(a_empty_result, aclk, aresetn,
        (m_valid && m_data.access_count == 2'd0) |->
            (m_data.access_bytes == 4'd0 && !m_data.access_is_write &&
             m_data.access_address_first == 32'd0 &&
             m_data.access_address_second == 32'd0),
        "dropped access left a record")
    `LDS_ASSERT(a_write_no_data, aclk, aresetn,
        (m_valid && m_data.access_is_write) |->
            (m_data.read_data_first == 64'd0 && m_data.read_data_second == 64'd0),
        "write returned read data")

endmodule

bind local_data_share_access_unit ldsau_checker u_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the local data share access unit, with a shadow scratch memory.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldsau_pkg::*;

    localparam int SCRATCH_BYTES = 65536;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [3:0] CMD_SPARE_LO = 4'd14;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    logic [7:0]         shadow_mem [SCRATCH_BYTES];
    bit                 shadow_known [SCRATCH_BYTES];
    logic [BOUND_W-1:0] top_q;
    logic [LIMIT_W-1:0] limit_q;
    out_item_t          awaited_results [$];
    int                 mismatches;
    bit                 calm;

    local_data_share_access_unit #(
        .MEMORY_BYTES(SCRATCH_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] cur_bound();
        logic [31:0] b;
        b = {{(32 - BOUND_W){1'b0}}, top_q};
        if (limit_q < b) b = limit_q;
        if (b > SCRATCH_BYTES) b = 32'(SCRATCH_BYTES);
        return b;
    endfunction

    function automatic bit is_write(logic [3:0] cmd);
        return cmd <= CMD_WR2X64;
    endfunction

    function automatic bit is_pair(logic [3:0] cmd);
        return cmd == CMD_WR2X32 || cmd == CMD_WR2X64 || cmd == CMD_RD2X32 || cmd == CMD_RD2X64;
    endfunction

    function automatic int access_size(logic [3:0] cmd);
        case (cmd)
            CMD_WR8, CMD_RDI8, CMD_RDU8: return 1;
            CMD_WR16, CMD_RDI16, CMD_RDU16: return 2;
            CMD_WR32, CMD_WR2X32, CMD_RD32, CMD_RD2X32: return 4;
            CMD_WR64, CMD_WR2X64, CMD_RD64, CMD_RD2X64: return 8;
            default: return 0;
        endcase
    endfunction

    function automatic int access_addresses(in_item_t r, output logic [31:0] a0,
                                            output logic [31:0] a1);
        int sh;
        sh = (r.cmd == CMD_WR2X32 || r.cmd == CMD_RD2X32) ? 2 : 3;
        a1 = '0;
        if (!is_pair(r.cmd)) begin
            a0 = r.base_address + {16'h0, r.offset_high, r.offset_low};
            return 1;
        end
        a0 = r.base_address + ({24'h0, r.offset_low} << sh);
        a1 = r.base_address + ({24'h0, r.offset_high} << sh);
        return 2;
    endfunction

    function automatic out_item_t execute_access(in_item_t r);
        out_item_t       res;
        logic [31:0]     where [2];
        logic [63:0]     value;
        logic [63:0]     data;
        longint unsigned a;
        int              n;
        int              slots;
        int              hits;
        res = '0;
        n = access_size(r.cmd);
        if (n == 0) return res;
        slots = access_addresses(r, where[0], where[1]);
        hits = 0;
        for (int k = 0; k < slots; k++) begin
            if (where[k] < cur_bound()) begin
                if (is_write(r.cmd)) begin
                    data = (k == 0) ? r.write_data_first : r.write_data_second;
                    for (int i = 0; i < n; i++) begin
                        a = {32'h0, where[k]} + 64'(i);
                        if (a < SCRATCH_BYTES) begin
                            shadow_mem[16'(a)] = 8'(data >> (8 * i));
                            shadow_known[16'(a)] = 1'b1;
                        end
                    end
                end else begin
                    value = '0;
                    for (int i = 0; i < n; i++) begin
                        a = {32'h0, where[k]} + 64'(i);
                        if (a < SCRATCH_BYTES) begin
                            value |= {56'h0, shadow_mem[16'(a)]} << (8 * i);
                        end
                    end
                    if (r.cmd == CMD_RDI8 && value[7]) value[63:8] = '1;
                    if (r.cmd == CMD_RDI16 && value[15]) value[63:16] = '1;
                    if (k == 0) res.read_data_first = value;
                    else res.read_data_second = value;
                end
                if (hits == 0) res.access_address_first = where[k];
                else res.access_address_second = where[k];
                hits++;
            end
        end
        res.access_count = 2'(hits);
        if (hits != 0) begin
            res.access_bytes = 4'(n);
            res.access_is_write = is_write(r.cmd);
        end
        return res;
    endfunction

    // True when every byte the request would read has been written before.
    function automatic bit reads_known(in_item_t r);
        logic [31:0]     where [2];
        longint unsigned a;
        int              n;
        int              slots;
        n = access_size(r.cmd);
        if (is_write(r.cmd) || n == 0) return 1'b1;
        slots = access_addresses(r, where[0], where[1]);
        for (int k = 0; k < slots; k++) begin
            if (where[k] < cur_bound()) begin
                for (int i = 0; i < n; i++) begin
                    a = {32'h0, where[k]} + 64'(i);
                    if (a < SCRATCH_BYTES && !shadow_known[16'(a)]) return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic in_item_t random_request(int write_pct);
        in_item_t    r;
        logic [31:0] target;
        logic [31:0] a0;
        logic [31:0] a1;
        int          sel;
        int          region;
        sel = $urandom_range(0, 99);
        if (sel < 2) r.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else if (sel < 2 + write_pct) r.cmd = 4'($urandom_range(CMD_WR8, CMD_WR2X64));
        else r.cmd = 4'($urandom_range(CMD_RDI8, CMD_RD2X64));
        region = $urandom_range(0, 99);
        if (region < 45) target = $urandom_range(0, 2047);
        else if (region < 65) target = 32'(SCRATCH_BYTES - 1) - $urandom_range(0, 511);
        else if (region < 80) target = cur_bound() - 32'd16 + $urandom_range(0, 32);
        else target = $urandom;
        r.offset_low = 8'($urandom);
        r.offset_high = 8'($urandom);
        if ($urandom_range(0, 1)) begin
            r.offset_low = 8'($urandom_range(0, 15));
            r.offset_high = is_pair(r.cmd) ? 8'($urandom_range(0, 15)) : 8'h00;
        end
        if (is_pair(r.cmd) && $urandom_range(0, 1)) begin
            r.offset_high = r.offset_low + 8'($urandom_range(0, 4));
        end
        r.base_address = '0;
        void'(access_addresses(r, a0, a1));
        r.base_address = target - a0;
        r.write_data_first = {$urandom, $urandom};
        r.write_data_second = {$urandom, $urandom};
        return r;
    endfunction

    function automatic in_item_t mk(logic [3:0] cmd, logic [31:0] base, logic [7:0] olo,
                                    logic [7:0] ohi, logic [63:0] d0, logic [63:0] d1);
        in_item_t r;
        r.cmd = cmd;
        r.base_address = base;
        r.offset_low = olo;
        r.offset_high = ohi;
        r.write_data_first = d0;
        r.write_data_second = d1;
        return r;
    endfunction

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (got === want) return 0;
        if (mismatches < 10) $display("mismatch %s: expected %h, got %h", name, want, got);
        return 1;
    endfunction

    function automatic void compare_result(out_item_t want, out_item_t got);
        int bad;
        bad = 0;
        bad += field_differs("read_data_first", want.read_data_first, got.read_data_first);
        bad += field_differs("read_data_second", want.read_data_second, got.read_data_second);
        bad += field_differs("access_count", 64'(want.access_count), 64'(got.access_count));
        bad += field_differs("access_address_first", 64'(want.access_address_first),
                             64'(got.access_address_first));
        bad += field_differs("access_address_second", 64'(want.access_address_second),
                             64'(got.access_address_second));
        bad += field_differs("access_bytes", 64'(want.access_bytes), 64'(got.access_bytes));
        bad += field_differs("access_is_write", 64'(want.access_is_write),
                             64'(got.access_is_write));
        if (bad != 0) mismatches++;
    endfunction

    initial begin
        int        stall;
        out_item_t want;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10) $display("mismatch: result with no request outstanding");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_result(want, m_data);
                end
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic apb_cycle(logic wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    task automatic program_config(logic [31:0] top, logic [31:0] lim);
        logic [31:0] got;
        apb_cycle(1'b1, REG_MEMORY_TOP, top, got);
        apb_cycle(1'b0, REG_MEMORY_TOP, '0, got);
        if (field_differs("memory_top", 64'(top[BOUND_W-1:0]), 64'(got[BOUND_W-1:0]))) begin
            mismatches++;
        end
        apb_cycle(1'b1, REG_LIMIT, lim, got);
        apb_cycle(1'b0, REG_LIMIT, '0, got);
        if (field_differs("limit_register", 64'(lim), 64'(got))) mismatches++;
        psel <= 1'b0;
        penable <= 1'b0;
        top_q = top[BOUND_W-1:0];
        limit_q = lim;
    endtask

    task automatic issue_request(in_item_t req);
        int gap;
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        awaited_results.push_back(execute_access(req));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int count, int write_pct);
        in_item_t req;
        int       tries;
        repeat (count) begin
            req = random_request(write_pct);
            tries = 0;
            while (!reads_known(req) && tries < 16) begin
                req = random_request(write_pct);
                tries++;
            end
            // fall back to a write so that unwritten bytes are never read
            if (!reads_known(req)) req.cmd = is_pair(req.cmd) ? CMD_WR2X64 : CMD_WR64;
            issue_request(req);
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] got;
        apb_cycle(1'b0, REG_MEMORY_TOP, '0, got);
        if (field_differs("memory_top", 64'(MEMORY_TOP_RESET), 64'(got[BOUND_W-1:0]))) begin
            mismatches++;
        end
        apb_cycle(1'b0, REG_LIMIT, '0, got);
        if (field_differs("limit_register", 64'(LIMIT_RESET), 64'(got))) mismatches++;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed();
        in_item_t plan [$];
        plan.push_back(mk(CMD_WR64, 32'h0, 8'h00, 8'h00, 64'h8899_AABB_CCDD_EEFF, '0));
        plan.push_back(mk(CMD_WR2X64, 32'h0, 8'h01, 8'h02, 64'h0123_4567_89AB_CDEF,
                          64'hFEDC_BA98_7654_3210));
        plan.push_back(mk(CMD_WR2X32, 32'h18, 8'h00, 8'hFF, 64'h1111_2222_3333_4444,
                          64'h5555_6666_7777_8888));
        plan.push_back(mk(CMD_WR32, 32'h100, 8'h00, 8'h01, 64'hFFFF_FFFF_8000_7F80, '0));
        plan.push_back(mk(CMD_WR16, 32'h204, 8'h00, 8'h00, 64'h8001, '0));
        plan.push_back(mk(CMD_WR8, 32'h206, 8'h00, 8'h00, 64'h80, '0));
        plan.push_back(mk(CMD_WR8, 32'h207, 8'h00, 8'h00, 64'h7F, '0));
        plan.push_back(mk(CMD_RDI8, 32'h206, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RDI8, 32'h207, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RDI16, 32'h204, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RDU16, 32'h204, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RD32, 32'h200, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RD64, 32'h0, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RD2X32, 32'h18, 8'h00, 8'hFF, '0, '0));
        plan.push_back(mk(CMD_RD2X64, 32'h0, 8'h01, 8'h02, '0, '0));
        // overlapping pair write: second element wins
        plan.push_back(mk(CMD_WR2X64, 32'h300, 8'h03, 8'h03, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555));
        plan.push_back(mk(CMD_RD64, 32'h300, 8'h18, 8'h00, '0, '0));
        // straddle the end of memory
        plan.push_back(mk(CMD_WR64, 32'hFFF8, 8'h04, 8'h00, 64'hCAFE_F00D_1234_5678, '0));
        plan.push_back(mk(CMD_RD64, 32'hFFFC, 8'h00, 8'h00, '0, '0));
        plan.push_back(mk(CMD_WR2X64, 32'hFFF8, 8'h00, 8'hFF, 64'h0F0F_0F0F_0F0F_0F0F,
                          64'hF0F0_F0F0_F0F0_F0F0));
        plan.push_back(mk(CMD_WR32, 32'h1_0000, 8'h00, 8'h00, 64'hDEAD_BEEF, '0));
        plan.push_back(mk(CMD_RD32, 32'hFFFF_FFF0, 8'h00, 8'h00, '0, '0));
        // address wraps around to zero
        plan.push_back(mk(CMD_RDU8, 32'hFFFF_FFFF, 8'h01, 8'h00, '0, '0));
        plan.push_back(mk(CMD_RD2X32, 32'hFFFF_FFFC, 8'h00, 8'h01, '0, '0));
        plan.push_back(mk(CMD_WR8, 32'hFFFF_FFFF, 8'hFF, 8'hFF, '1, '1));
        plan.push_back(mk(CMD_SPARE_LO, '1, 8'hFF, 8'hFF, '1, '1));
        plan.push_back(mk(CMD_SPARE_HI, '0, 8'h00, 8'h00, '0, '0));
        foreach (plan[i]) issue_request(plan[i]);
        wait_idle();
    endtask

    task automatic test_bounds();
        logic [31:0] tops [7] = '{32'd0, 32'd65536, 32'd1, 32'd1024, 32'd65535, 32'd40000,
                                  32'd4096};
        logic [31:0] limits [7] = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd700,
                                    32'h0001_0000, 32'hFFFF_0000, 32'h0000_2000};
        foreach (tops[i]) begin
            program_config(tops[i], limits[i]);
            run_random(70, 45);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        program_config({{(32 - BOUND_W){1'b0}}, MEMORY_TOP_RESET}, LIMIT_RESET);
        calm = 1'b1;
        run_random(200, 35);
        calm = 1'b0;
        run_random(1000, 35);
        wait_idle();
    endtask

    initial begin
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        top_q = MEMORY_TOP_RESET;
        limit_q = LIMIT_RESET;
        mismatches = 0;
        calm = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_directed();
        test_bounds();
        test_random_traffic();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
